### hdl/text_console_writer_core_macros.svh
// assertion macros shared by the console checker
// expects signals named clk and rst_n in the scope of use
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define TCW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console check failed");

// next-cycle implication, held off during reset
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console check failed");

`endif

### hdl/tcw_pkg.sv
// shared types, constants and address helpers of the text console
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(CELL_COUNT);

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_BKSP  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_RETURN    = 8'd13;
    localparam logic [7:0] GLYPH_SPACE    = 8'h20;
    localparam logic [7:0] GLYPH_PROMPT   = 8'h3E;
    localparam logic [7:0] COLOR_AT_RESET = 8'd31;

    localparam logic [CELL_W-1:0] FILL_CELL = {COLOR_AT_RESET, GLYPH_SPACE};

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       char_code;
        logic             prompt_after_break;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_col;
    } tcw_cmd_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } tcw_res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } tcw_wr_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] addr;
    } tcw_rd_t;

    // row sum modulo the screen height, both operands below the height
    function automatic logic [ROW_W-1:0] row_wrap(input logic [ROW_W-1:0] a,
                                                  input logic [ROW_W-1:0] b);
        logic [ROW_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (ROW_W+1)'(SCREEN_HEIGHT))
            s = s - (ROW_W+1)'(SCREEN_HEIGHT);
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

### hdl/text_console_writer_core.sv
// work per item: a plain character is one write, a prompt adds two ordinary glyph writes,
// a scroll blanks the new bottom row column by column, a clear rewrites every cell
// one item in flight; the next item is taken the cycle after the result moves to
// the output register
// reset: cursor home, colour 31, then a clearing pass over the whole store with s_axis_tready low
// depends on tcw_pkg, tcw_screen_ram, tcw_engine
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core
    import tcw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // command items
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // char_code[7:0], prompt_after_break[8], read_row[13:9], read_col[20:14]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]             s_axis_tuser,
    // result items
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // cell_value[15:0], cursor_row[20:16], cursor_col[27:21]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // text colour register
    input  wire logic                   cfg_we,
    input  wire logic [7:0]             cfg_wdata
);

    tcw_cmd_t          cmd;
    tcw_res_t          res;
    tcw_wr_t           mem_wr;
    tcw_rd_t           mem_rd;
    logic [CELL_W-1:0] mem_rdata;
    logic              color_clear;
    logic              res_valid;
    logic              res_ready;

    logic [7:0]        color_reg;
    logic              out_valid_reg;
    tcw_res_t          out_res_reg;

    // unpack the command item
    assign cmd.kind               = s_axis_tuser;
    assign cmd.char_code          = s_axis_tdata[7:0];
    assign cmd.prompt_after_break = s_axis_tdata[8];
    assign cmd.read_row           = s_axis_tdata[13:9];
    assign cmd.read_col           = s_axis_tdata[20:14];

    // colour register: a clear puts the reset colour back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_reg <= COLOR_AT_RESET;
        else if (color_clear)
            color_reg <= COLOR_AT_RESET;
        else if (cfg_we)
            color_reg <= cfg_wdata;
    end

    // screen store: rows are held in a ring, the engine tracks the top row
    tcw_screen_ram #(
        .DEPTH  (CELL_COUNT),
        .DATA_W (CELL_W),
        .ADDR_W (ADDR_W)
    ) u_screen_ram (
        .clk   (clk),
        .we    (mem_wr.we),
        .waddr (mem_wr.addr),
        .wdata (mem_wr.data),
        .re    (mem_rd.re),
        .raddr (mem_rd.addr),
        .rdata (mem_rdata)
    );

    tcw_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (s_axis_tvalid),
        .cmd_ready   (s_axis_tready),
        .cmd         (cmd),
        .text_color  (color_reg),
        .color_clear (color_clear),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr      (mem_wr),
        .mem_rd      (mem_rd),
        .mem_rdata   (mem_rdata)
    );

    // output register decouples the engine from a stalled consumer
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_res_reg.cursor_col, out_res_reg.cursor_row,
                            out_res_reg.cell_value};

endmodule

`default_nettype wire

### hdl/tcw_screen_ram.sv
// simple dual-port screen store, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int DATA_W = 16,
    parameter int ADDR_W = 11
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/tcw_engine.sv
// command sequencer: cursor, scroll origin and all screen store traffic
// depends on tcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcw_engine
    import tcw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire tcw_cmd_t    cmd,
    input  wire logic [7:0]  text_color,
    output logic             color_clear,
    output logic             res_valid,
    input  wire logic        res_ready,
    output tcw_res_t         res,
    output tcw_wr_t          mem_wr,
    output tcw_rd_t          mem_rd,
    input  wire logic [CELL_W-1:0] mem_rdata
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_WRITE  = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_CONT   = 3'd4;
    localparam logic [2:0] ST_READ   = 3'd5;
    localparam logic [2:0] ST_CLEAR  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_WIDTH - 1);

    logic [2:0]        state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [7:0]        glyph_reg, glyph_next;
    logic [1:0]        prompt_left_reg, prompt_left_next;
    logic [CELL_W-1:0] value_reg, value_next;

    logic [ROW_W-1:0]  cur_prow;
    logic              read_in_range;

    assign cur_prow      = row_wrap(row_reg, top_reg);
    assign read_in_range = ({1'b0, cmd.read_row} < (ROW_W+1)'(SCREEN_HEIGHT)) &&
                           ({1'b0, cmd.read_col} < (COL_W+1)'(SCREEN_WIDTH));

    always_comb
    begin
        state_next       = state_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        top_next         = top_reg;
        cnt_next         = cnt_reg;
        base_next        = base_reg;
        glyph_next       = glyph_reg;
        prompt_left_next = prompt_left_reg;
        value_next       = value_reg;
        cmd_ready        = 1'b0;
        color_clear      = 1'b0;
        res_valid        = 1'b0;
        mem_wr           = '0;
        mem_rd           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    value_next = '0;
                    case (cmd.kind)
                        KIND_PUT:
                        begin
                            if (cmd.char_code == CODE_NEWLINE ||
                                cmd.char_code == CODE_RETURN)
                            begin
                                col_next         = '0;
                                prompt_left_next = cmd.prompt_after_break ? 2'd2 : 2'd0;
                                state_next       = ST_CONT;
                                if (cmd.char_code == CODE_NEWLINE)
                                begin
                                    if (row_reg == LAST_ROW)
                                    begin
                                        // bottom reached: old top row becomes the new bottom
                                        base_next  = cell_addr(top_reg, '0);
                                        top_next   = row_wrap(top_reg, ROW_W'(1));
                                        cnt_next   = '0;
                                        state_next = ST_SCROLL;
                                    end
                                    else
                                        row_next = row_reg + ROW_W'(1);
                                end
                            end
                            else
                            begin
                                glyph_next       = cmd.char_code;
                                prompt_left_next = 2'd0;
                                state_next       = ST_WRITE;
                            end
                        end
                        KIND_BKSP:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next    = col_reg - COL_W'(1);
                                mem_wr.we   = 1'b1;
                                mem_wr.addr = cell_addr(cur_prow, col_reg - COL_W'(1));
                                mem_wr.data = {text_color, GLYPH_SPACE};
                            end
                            state_next = ST_DONE;
                        end
                        KIND_CLEAR:
                        begin
                            color_clear = 1'b1;
                            cnt_next    = '0;
                            state_next  = ST_CLEAR;
                        end
                        default:
                        begin
                            if (read_in_range)
                            begin
                                mem_rd.re   = 1'b1;
                                mem_rd.addr = cell_addr(row_wrap(cmd.read_row, top_reg),
                                                        cmd.read_col);
                                state_next  = ST_READ;
                            end
                            else
                                state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = cell_addr(cur_prow, col_reg);
                mem_wr.data = {text_color, glyph_reg};
                state_next  = ST_CONT;
                if (col_reg == LAST_COL)
                begin
                    col_next = '0;
                    if (row_reg == LAST_ROW)
                    begin
                        base_next  = cell_addr(top_reg, '0);
                        top_next   = row_wrap(top_reg, ROW_W'(1));
                        cnt_next   = '0;
                        state_next = ST_SCROLL;
                    end
                    else
                        row_next = row_reg + ROW_W'(1);
                end
                else
                    col_next = col_reg + COL_W'(1);
            end
            ST_SCROLL:
            begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = base_reg + cnt_reg;
                mem_wr.data = {text_color, GLYPH_SPACE};
                if (cnt_reg[COL_W-1:0] == LAST_COL)
                    state_next = ST_CONT;
                else
                    cnt_next = cnt_reg + ADDR_W'(1);
            end
            ST_CONT:
            begin
                // prompt characters go through the ordinary write path
                case (prompt_left_reg)
                    2'd2:
                    begin
                        glyph_next       = GLYPH_PROMPT;
                        prompt_left_next = 2'd1;
                        state_next       = ST_WRITE;
                    end
                    2'd1:
                    begin
                        glyph_next       = GLYPH_SPACE;
                        prompt_left_next = 2'd0;
                        state_next       = ST_WRITE;
                    end
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_READ:
            begin
                value_next = mem_rdata;
                state_next = ST_DONE;
            end
            ST_INIT, ST_CLEAR:
            begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = cnt_reg;
                mem_wr.data = FILL_CELL;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    row_next   = '0;
                    col_next   = '0;
                    top_next   = '0;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
                else
                    cnt_next = cnt_reg + ADDR_W'(1);
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            row_reg         <= '0;
            col_reg         <= '0;
            top_reg         <= '0;
            cnt_reg         <= '0;
            prompt_left_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            top_reg         <= top_next;
            cnt_reg         <= cnt_next;
            prompt_left_reg <= prompt_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        glyph_reg <= glyph_next;
        value_reg <= value_next;
    end

    assign res.cell_value = value_reg;
    assign res.cursor_row = row_reg;
    assign res.cursor_col = col_reg;

endmodule

`default_nettype wire

### hdl/tcw_checker.sv
// port-level checks of the text console, bound to the top level
// depends on tcw_pkg and text_console_writer_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_writer_core_macros.svh"

module tcw_checker
    import tcw_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;

    assign out_row = m_axis_tdata[20:16];
    assign out_col = m_axis_tdata[27:21];

    // a stalled result holds
    `TCW_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))
    // one item in flight: the cycle after an accept takes nothing new
    `TCW_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // cursor stays on the screen
    `TCW_ASSERT_NOW(a_cursor_on_screen, m_axis_tvalid,
                    ({1'b0, out_row} < (ROW_W+1)'(SCREEN_HEIGHT)) &&
                    ({1'b0, out_col} < (COL_W+1)'(SCREEN_WIDTH)))
    // padding bits of the result are zero
    `TCW_ASSERT_NOW(a_out_pad, m_axis_tvalid, m_axis_tdata[31:28] == 4'b0000)

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### verif/text_console_writer_core_test.sv
// self-checking testbench for text_console_writer_core: directed plan, then random bursts
// keeps its own shadow of screen store, cursor and colour and compares every result item
// depends on tcw_pkg and text_console_writer_core
`timescale 1ns / 1ps

module text_console_writer_core_test;
    import tcw_pkg::*;

    // run shape
    localparam int RANDOM_ITEMS    = 1875;
    localparam int PHASES          = 6;
    localparam int IDLE_PERCENT    = 25;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int SETTLE_CYCLES   = 50;
    // slowest correct run is every item a full clear plus a long receiver hold-off
    // and sender gaps; the guard lies above it
    localparam int LIMIT_CYCLES    = 16_000_000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [7:0]             cfg_wdata;

    // shadow of the console: screen store, cursor and current colour
    logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
    int unsigned       cursor_r;
    int unsigned       cursor_c;
    logic [7:0]        shadow_colour;

    // cursor reports still owed by the block, oldest first
    tcw_res_t expected_reports [$];

    // directed plan: command, whether the answer is typed in, and that answer
    tcw_cmd_t plan_cmds  [$];
    bit       plan_typed [$];
    tcw_res_t plan_res   [$];

    int  mismatches;
    int  items_sent;
    int  cycle_count;
    bit  steady;            // no idling on either side while set
    bit  hold_off_req;      // asks the receiver for one long stall
    int  hold_off_left;

    text_console_writer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // shadow console
    // ---------------------------------------------------------------

    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++)
            shadow_screen[i] = {shadow_colour, GLYPH_SPACE};
    endfunction

    // next row; at the bottom everything moves up one row and a blank row
    // in the current colour comes in underneath
    function automatic void line_feed();
        cursor_r++;
        if (cursor_r >= SCREEN_HEIGHT)
        begin
            for (int i = 0; i < CELL_COUNT - SCREEN_WIDTH; i++)
                shadow_screen[i] = shadow_screen[i + SCREEN_WIDTH];
            for (int i = CELL_COUNT - SCREEN_WIDTH; i < CELL_COUNT; i++)
                shadow_screen[i] = {shadow_colour, GLYPH_SPACE};
            cursor_r = SCREEN_HEIGHT - 1;
        end
    endfunction

    // glyph at the cursor, then advance with wrap at the line end
    function automatic void emit_glyph(input logic [7:0] glyph);
        shadow_screen[cursor_r * SCREEN_WIDTH + cursor_c] = {shadow_colour, glyph};
        cursor_c++;
        if (cursor_c >= SCREEN_WIDTH)
        begin
            cursor_c = 0;
            line_feed();
        end
    endfunction

    // applies one command to the shadow and returns the cursor report it should give
    function automatic tcw_res_t apply_command(input tcw_cmd_t c);
        tcw_res_t r;
        r.cell_value = '0;
        case (c.kind)
            KIND_PUT:
            begin
                if (c.char_code == CODE_NEWLINE || c.char_code == CODE_RETURN)
                begin
                    cursor_c = 0;
                    if (c.char_code == CODE_NEWLINE)
                        line_feed();
                    // prompt is written as two ordinary glyphs, so it may wrap or scroll
                    if (c.prompt_after_break)
                    begin
                        emit_glyph(GLYPH_PROMPT);
                        emit_glyph(GLYPH_SPACE);
                    end
                end
                else
                    emit_glyph(c.char_code);
            end
            KIND_BKSP:
            begin
                // never climbs back to the row above
                if (cursor_c > 0)
                begin
                    cursor_c--;
                    shadow_screen[cursor_r * SCREEN_WIDTH + cursor_c] =
                        {shadow_colour, GLYPH_SPACE};
                end
            end
            KIND_CLEAR:
            begin
                // clear also puts the colour back to its reset value
                shadow_colour = COLOR_AT_RESET;
                blank_screen();
                cursor_r = 0;
                cursor_c = 0;
            end
            default:
            begin
                // reads off the screen answer zero
                if (c.read_row < SCREEN_HEIGHT && c.read_col < SCREEN_WIDTH)
                    r.cell_value = shadow_screen[c.read_row * SCREEN_WIDTH + c.read_col];
            end
        endcase
        r.cursor_row = cursor_r[ROW_W-1:0];
        r.cursor_col = cursor_c[COL_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // command building
    // ---------------------------------------------------------------

    function automatic tcw_cmd_t make_cmd(input logic [1:0] kind, input logic [7:0] code,
                                          input logic prompt, input logic [ROW_W-1:0] rrow,
                                          input logic [COL_W-1:0] rcol);
        tcw_cmd_t c;
        c.kind               = kind;
        c.char_code          = code;
        c.prompt_after_break = prompt;
        c.read_row           = rrow;
        c.read_col           = rcol;
        return c;
    endfunction

    function automatic tcw_res_t make_res(input logic [CELL_W-1:0] value,
                                          input logic [ROW_W-1:0] row,
                                          input logic [COL_W-1:0] col);
        tcw_res_t r;
        r.cell_value = value;
        r.cursor_row = row;
        r.cursor_col = col;
        return r;
    endfunction

    // every field random; the unused ones of a command must be ignored by the block
    function automatic tcw_cmd_t noise_cmd();
        return make_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), ROW_W'($urandom_range(0, 31)),
                        COL_W'($urandom_range(0, 127)));
    endfunction

    // mostly printable text, now and then any byte at all
    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 15) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    task automatic plan_step(input tcw_cmd_t c, input bit typed, input tcw_res_t r);
        plan_cmds.push_back(c);
        plan_typed.push_back(typed);
        plan_res.push_back(r);
    endtask

    // ---------------------------------------------------------------
    // command side
    // ---------------------------------------------------------------

    // offers one item, random gaps first; the shadow moves on at the accepting edge
    task automatic send_cmd(input tcw_cmd_t c, input bit typed, input tcw_res_t typed_res);
        tcw_res_t predicted;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, c.read_col, c.read_row, c.prompt_after_break, c.char_code};
        s_axis_tuser  <= c.kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = apply_command(c);
        expected_reports.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    task automatic send_random(input tcw_cmd_t c);
        send_cmd(c, 1'b0, '0);
    endtask

    // stop offering and wait for every owed report
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // colour register; only written with the block idle
    task automatic write_colour(input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow_colour = value;
    endtask

    // one burst of random work; text lines ending in a break are the bulk,
    // so the cursor wraps, scrolls and writes prompts often
    task automatic random_burst();
        tcw_cmd_t c;
        int       sel;
        int       n;
        sel = $urandom_range(0, 99);
        if (sel < 45)
        begin
            // text line, now and then longer than a screen row
            n = $urandom_range(0, 40);
            if ($urandom_range(0, 7) == 0)
                n = $urandom_range(80, 170);
            for (int i = 0; i < n; i++)
            begin
                c = noise_cmd();
                c.kind = KIND_PUT;
                c.char_code = text_byte();
                send_random(c);
            end
            c = noise_cmd();
            c.kind = KIND_PUT;
            c.char_code = ($urandom_range(0, 9) < 7) ? CODE_NEWLINE : CODE_RETURN;
            send_random(c);
        end
        else if (sel < 60)
        begin
            // run of newlines, enough to reach the bottom and scroll
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++)
            begin
                c = noise_cmd();
                c.kind = KIND_PUT;
                c.char_code = CODE_NEWLINE;
                send_random(c);
            end
        end
        else if (sel < 80)
        begin
            // reads, mostly on the screen, some off it
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
            begin
                c = noise_cmd();
                c.kind = KIND_READ;
                if ($urandom_range(0, 9) != 0)
                begin
                    c.read_row = ROW_W'($urandom_range(0, SCREEN_HEIGHT - 1));
                    c.read_col = COL_W'($urandom_range(0, SCREEN_WIDTH - 1));
                end
                send_random(c);
            end
        end
        else if (sel < 90)
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
            begin
                c = noise_cmd();
                c.kind = KIND_BKSP;
                send_random(c);
            end
        end
        else if (sel < 98)
        begin
            // anything at all, clears kept rare since each walks the whole store
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                c = noise_cmd();
                if (c.kind == KIND_CLEAR && $urandom_range(0, 3) != 0)
                    c.kind = KIND_READ;
                send_random(c);
            end
        end
        else
        begin
            c = noise_cmd();
            c.kind = KIND_CLEAR;
            send_random(c);
        end
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    // random back-pressure, one long stall on request, none while steady
    always @(negedge clk)
    begin
        if (hold_off_req)
        begin
            hold_off_left = HOLD_OFF_CYCLES;
            hold_off_req  = 1'b0;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            m_axis_tready <= 1'b0;
        end
        else if (steady)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s expected %0h got %0h",
                     cycle_count, what, want, got);
    endtask

    // each result item against the oldest owed report, field by field
    always @(posedge clk)
    begin
        tcw_res_t seen;
        tcw_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.cell_value = m_axis_tdata[15:0];
            seen.cursor_row = m_axis_tdata[20:16];
            seen.cursor_col = m_axis_tdata[27:21];
            if (expected_reports.size() == 0)
                flag_mismatch("result item with none owed", '0, m_axis_tdata);
            else
            begin
                want = expected_reports.pop_front();
                if (seen.cell_value != want.cell_value)
                    flag_mismatch("cell_value", 32'(want.cell_value),
                                  32'(seen.cell_value));
                if (seen.cursor_row != want.cursor_row)
                    flag_mismatch("cursor_row", 32'(want.cursor_row),
                                  32'(seen.cursor_row));
                if (seen.cursor_col != want.cursor_col)
                    flag_mismatch("cursor_col", 32'(want.cursor_col),
                                  32'(seen.cursor_col));
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial
    begin
        logic [7:0] colour;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_PUT;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        mismatches    = 0;
        items_sent    = 0;
        cycle_count   = 0;
        steady        = 1'b0;
        hold_off_req  = 1'b0;
        hold_off_left = 0;

        shadow_colour = COLOR_AT_RESET;
        blank_screen();
        cursor_r = 0;
        cursor_c = 0;

        // directed plan, reset colour throughout
        // fresh screen, corners and reads off the screen
        plan_step(make_cmd(KIND_READ, 8'h00, 1'b0, 5'd0, 7'd0), 1'b1,
                  make_res(FILL_CELL, 5'd0, 7'd0));
        plan_step(make_cmd(KIND_READ, 8'h00, 1'b0, 5'd24, 7'd79), 1'b1,
                  make_res(FILL_CELL, 5'd0, 7'd0));
        plan_step(make_cmd(KIND_READ, 8'hFF, 1'b1, 5'd25, 7'd0), 1'b1,
                  make_res('0, 5'd0, 7'd0));
        plan_step(make_cmd(KIND_READ, 8'h00, 1'b0, 5'd31, 7'd127), 1'b1,
                  make_res('0, 5'd0, 7'd0));
        plan_step(make_cmd(KIND_READ, 8'h00, 1'b0, 5'd0, 7'd80), 1'b1,
                  make_res('0, 5'd0, 7'd0));
        // backspace at column 0 does nothing
        plan_step(make_cmd(KIND_BKSP, 8'h00, 1'b0, 5'd0, 7'd0), 1'b1,
                  make_res('0, 5'd0, 7'd0));
        plan_step(make_cmd(KIND_PUT, 8'h41, 1'b0, 5'd0, 7'd0), 1'b1,
                  make_res('0, 5'd0, 7'd1));
        // glyph extremes
        plan_step(make_cmd(KIND_PUT, 8'hFF, 1'b0, 5'd31, 7'd127), 1'b0, '0);
        plan_step(make_cmd(KIND_PUT, 8'h00, 1'b0, 5'd0, 7'd0), 1'b0, '0);
        plan_step(make_cmd(KIND_READ, 8'h00, 1'b0, 5'd0, 7'd1), 1'b0, '0);
        plan_step(make_cmd(KIND_BKSP, 8'hFF, 1'b1, 5'd31, 7'd127), 1'b0, '0);
        plan_step(make_cmd(KIND_READ, 8'h00, 1'b0, 5'd0, 7'd2), 1'b0, '0);
        // line breaks with and without prompt
        plan_step(make_cmd(KIND_PUT, CODE_RETURN, 1'b1, 5'd0, 7'd0), 1'b0, '0);
        plan_step(make_cmd(KIND_PUT, CODE_NEWLINE, 1'b0, 5'd0, 7'd0), 1'b0, '0);
        plan_step(make_cmd(KIND_PUT, CODE_NEWLINE, 1'b1, 5'd0, 7'd0), 1'b0, '0);
        plan_step(make_cmd(KIND_PUT, CODE_RETURN, 1'b0, 5'd0, 7'd0), 1'b0, '0);
        plan_step(make_cmd(KIND_READ, 8'h00, 1'b0, 5'd2, 7'd0), 1'b0, '0);
        plan_step(make_cmd(KIND_READ, 8'h00, 1'b0, 5'd0, 7'd0), 1'b0, '0);
        // prompt flag on a plain glyph has no effect
        plan_step(make_cmd(KIND_PUT, 8'h7E, 1'b1, 5'd0, 7'd0), 1'b0, '0);
        // clear homes the cursor and blanks the screen
        plan_step(make_cmd(KIND_CLEAR, 8'hFF, 1'b1, 5'd31, 7'd127), 1'b1,
                  make_res('0, 5'd0, 7'd0));
        plan_step(make_cmd(KIND_READ, 8'h00, 1'b0, 5'd2, 7'd0), 1'b1,
                  make_res(FILL_CELL, 5'd0, 7'd0));
        plan_step(make_cmd(KIND_READ, CODE_NEWLINE, 1'b1, 5'd24, 7'd0), 1'b0, '0);

        // reset held low first; the block then runs its clearing pass with tready low
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < plan_cmds.size(); i++)
            send_cmd(plan_cmds[i], plan_typed[i], plan_res[i]);
        drain();

        // random phases, each behind a colour write with the block idle
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                colour = 8'h00;
            else if (phase == 1)
                colour = 8'hFF;
            else
                colour = 8'($urandom_range(0, 255));
            write_colour(colour);
            // long receiver stall while commands keep coming, so the input backs up
            if (phase == 1)
                hold_off_req = 1'b1;
            // one phase with no idling at all
            steady = (phase == 3);
            while (items_sent < plan_cmds.size() + (phase + 1) * RANDOM_ITEMS / PHASES)
                random_burst();
            // sender waits here until every owed report is back
            drain();
        end
        steady = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
